>>> src/clt_pkg.sv
// shared types and codes for the compacting list table
package clt_pkg;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic append;
		logic remove;
		logic compare;
		logic shift;
	} cell_cmd_t;

endpackage

>>> src/clt_cell.sv
// one storage cell of the list: entry, compacting shift and search match flag
module clt_cell import clt_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5,
	parameter int CELL_INDEX = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [CNT_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0] val,
	input  logic [DATA_WIDTH-1:0] next_entry,
	input  logic                  next_match,
	output logic [DATA_WIDTH-1:0] entry_q,
	output logic                  match_q
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);

	always_ff @(posedge clk) begin
		if (cmd.append && cnt == MY_POS) begin
			entry_q <= val;
		end else if (cmd.remove && MY_POS >= pos) begin
			entry_q <= next_entry;
		end
		if (cmd.compare) begin
			match_q <= (entry_q == val);
		end else if (cmd.shift) begin
			match_q <= next_match;
		end
	end

endmodule

>>> src/compacting_list_table_unit.sv
// top level of the compacting list table: request control and row of cells
//
// Ordered list of up to MAX_ENTRIES values held in a row of cells.
// Request channel: req_valid / req_stall with req_type, data_value and
// entry_index; a beat is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with status, found, found_index,
// element_count and list_capacity; exactly one response beat per request.
// Append, remove and unused codes: the response is registered directly from
// the request beat. Search: every cell compares at once, then the match flags
// shift toward cell 0 until cell 0 shows a hit or the step reaches the count;
// a search of an empty list gets its miss response directly from the beat.
// One request is in flight at a time: req_stall is high during a search and
// while a response waits under rsp_stall. Peak rate is one request per cycle
// for append and remove when the response side keeps up.
// Reset empties the list, sets the capacity to one and drops any pending
// response. While a response waits under rsp_stall it holds and no new
// request is taken.
module compacting_list_table_unit import clt_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] data_value,
	input  logic [3:0]  entry_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [3:0]  found_index,
	output logic [4:0]  element_count,
	output logic [4:0]  list_capacity
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = $clog2(MAX_ENTRIES) + 1;
	localparam int IW    = (CNT_W > 4) ? CNT_W : 4;

	logic [CNT_W-1:0]      count_q, count_d;
	logic [CAP_W-1:0]      cap_q, cap_d;
	logic                  busy_q, busy_d;
	logic [CNT_W-1:0]      step_q, step_d, step_inc;
	logic                  rsp_valid_q;
	logic [1:0]            status_q, status_d;
	logic                  found_q, found_d;
	logic [CNT_W-1:0]      fidx_q, fidx_d;
	logic                  ld_rsp;
	logic                  req_fire;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] val;
	logic [CNT_W-1:0]      pos;
	logic [DATA_WIDTH-1:0] entry_w [MAX_ENTRIES];
	logic                  match_w [MAX_ENTRIES];

	assign val       = DATA_WIDTH'(data_value);
	assign pos       = CNT_W'(entry_index);
	assign req_stall = busy_q || (rsp_valid_q && rsp_stall);
	assign req_fire  = req_valid && !req_stall;
	assign step_inc  = step_q + CNT_W'(1);

	always_comb begin
		cmd      = '0;
		ld_rsp   = 1'b0;
		status_d = ST_DONE;
		found_d  = 1'b0;
		fidx_d   = '0;
		count_d  = count_q;
		cap_d    = cap_q;
		busy_d   = busy_q;
		step_d   = step_q;
		if (busy_q) begin
			cmd.shift = 1'b1;
			if (match_w[0]) begin
				ld_rsp  = 1'b1;
				found_d = 1'b1;
				fidx_d  = step_q;
				busy_d  = 1'b0;
			end else if (step_inc == count_q) begin
				ld_rsp = 1'b1;
				busy_d = 1'b0;
			end else begin
				step_d = step_inc;
			end
		end else if (req_fire) begin
			case (req_type)
				REQ_APPEND: begin
					ld_rsp = 1'b1;
					if (count_q == CNT_W'(MAX_ENTRIES)) begin
						status_d = ST_FULL;
					end else begin
						cmd.append = 1'b1;
						count_d    = count_q + CNT_W'(1);
						if (CAP_W'(count_q) >= cap_q) begin
							cap_d = cap_q << 1;
						end
					end
				end
				REQ_SEARCH: begin
					if (count_q == '0) begin
						ld_rsp = 1'b1;
					end else begin
						cmd.compare = 1'b1;
						busy_d      = 1'b1;
						step_d      = '0;
					end
				end
				REQ_REMOVE: begin
					ld_rsp = 1'b1;
					if (IW'(entry_index) >= IW'(count_q)) begin
						status_d = ST_RANGE;
					end else begin
						cmd.remove = 1'b1;
						count_d    = count_q - CNT_W'(1);
						if (CAP_W'(count_d) < (cap_q >> 1)) begin
							cap_d = cap_q >> 1;
						end
					end
				end
				default: begin
					ld_rsp = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_W'(1);
			busy_q      <= 1'b0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			cap_q   <= cap_d;
			busy_q  <= busy_d;
			step_q  <= step_d;
			if (ld_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_rsp) begin
			status_q <= status_d;
			found_q  <= found_d;
			fidx_q   <= fidx_d;
		end
	end

	// response beat reports count and capacity as they stand after the request
	logic [CNT_W-1:0] rsp_count_q;
	logic [CAP_W-1:0] rsp_cap_q;

	always_ff @(posedge clk) begin
		if (ld_rsp) begin
			rsp_count_q <= count_d;
			rsp_cap_q   <= cap_d;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign found         = found_q;
	assign found_index   = 4'(fidx_q);
	assign element_count = 5'(rsp_count_q);
	assign list_capacity = 5'(rsp_cap_q);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] nxt_entry;
		logic                  nxt_match;
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign nxt_entry = entry_w[i];
			assign nxt_match = 1'b0;
		end else begin : g_mid
			assign nxt_entry = entry_w[i+1];
			assign nxt_match = match_w[i+1];
		end
		clt_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.CELL_INDEX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cnt        (count_q),
			.pos        (pos),
			.val        (val),
			.next_entry (nxt_entry),
			.next_match (nxt_match),
			.entry_q    (entry_w[i]),
			.match_q    (match_w[i])
		);
	end

`ifndef SYNTHESIS
	a_cap_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cap_q))
		else $error("capacity not a power of two");

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CAP_W'(count_q) <= cap_q)
		else $error("count exceeds capacity");

	a_search_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < count_q))
		else $error("search step past end of list");

	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !busy_d) |=> (rsp_valid_q && !busy_q))
		else $error("search finished without a response beat");
`endif

endmodule
